/* rtl/ibl_pkg.sv */
// ibl_pkg: request modes, status codes and the per-cell command type
// shared by the indexed byte list cells and its top level; no dependencies
package ibl_pkg;

   localparam int POS_W   = 5;
   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 3;
   localparam int STAT_W  = 2;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic              shift_up;
      logic              shift_down;
      logic              load;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] value;
   } cell_cmd_type;

endpackage

/* rtl/ibl_cell.sv */
// ibl_cell: one list slot holding a byte, shifting to and from its neighbors
// depends on ibl_pkg for the command struct
module ibl_cell #(
   parameter int INDEX = 0,
   parameter int CMP_W = 5
) (
   input  logic                      clock,
   input  ibl_pkg::cell_cmd_type     cmd,
   input  logic [ibl_pkg::BYTE_W-1:0] left_data,
   input  logic [ibl_pkg::BYTE_W-1:0] right_data,
   output logic [ibl_pkg::BYTE_W-1:0] data,
   output logic [ibl_pkg::BYTE_W-1:0] read_data
);
   import ibl_pkg::*;

   logic [BYTE_W-1:0] entry_ff;
   logic [BYTE_W-1:0] entry_in;
   logic [CMP_W-1:0]  my_idx;
   logic [CMP_W-1:0]  pos;

   assign my_idx = CMP_W'(INDEX);
   assign pos    = CMP_W'(cmd.position);

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.shift_up) begin
         if (my_idx > pos) begin
            entry_in = left_data;
         end else if (my_idx == pos) begin
            entry_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (my_idx >= pos) begin
            entry_in = right_data;
         end
      end else if (cmd.load) begin
         if (my_idx == pos) begin
            entry_in = cmd.value;
         end
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data      = entry_ff;
   assign read_data = (my_idx == pos) ? entry_ff : '0;

endmodule

/* rtl/indexed_byte_list.sv */
// indexed_byte_list: ordered byte list kept in a row of shifting cells
// rsp_valid rises in the cycle after start; one request per cycle, busy stays low
// every cell compares its index with the position, so insert and remove shift all cells together
// synchronous reset empties the list; entry bytes are not cleared
// the receiver cannot stall, each result shows for exactly one cycle
// depends on ibl_pkg and ibl_cell
module indexed_byte_list #(
   parameter int CAPACITY = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [ibl_pkg::MODE_W-1:0]  req_mode,
   input  logic [ibl_pkg::POS_W-1:0]   req_position,
   input  logic [ibl_pkg::BYTE_W-1:0]  req_value,
   output logic                        rsp_valid,
   output logic [ibl_pkg::BYTE_W-1:0]  rsp_read_byte,
   output logic [ibl_pkg::POS_W-1:0]   rsp_count,
   output logic                        rsp_empty_res,
   output logic [ibl_pkg::STAT_W-1:0]  rsp_status
);
   import ibl_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_read_byte_ff;
   logic [BYTE_W-1:0] rsp_read_byte_in;
   logic [POS_W-1:0]  rsp_count_ff;
   logic              rsp_empty_ff;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [STAT_W-1:0] rsp_status_in;

   logic              accept;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  cnt_ext;
   logic [CMP_W-1:0]  cap_ext;
   logic [BYTE_W-1:0] read_or;
   cell_cmd_type      cmd;

   logic [BYTE_W-1:0] cell_data [CAPACITY];
   logic [BYTE_W-1:0] cell_read [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start & ~busy;
   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);
   assign cap_ext = CMP_W'(CAPACITY);

   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | cell_read[i];
      end
   end

   always_comb begin
      cmd.shift_up     = 1'b0;
      cmd.shift_down   = 1'b0;
      cmd.load         = 1'b0;
      cmd.position     = req_position;
      cmd.value        = req_value;
      count_in         = count_ff;
      rsp_status_in    = ST_DONE;
      rsp_read_byte_in = '0;
      unique case (req_mode)
         MODE_INSERT: begin
            if (pos_ext > cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else if (cnt_ext >= cap_ext) begin
               rsp_status_in = ST_FULL;
            end else begin
               cmd.shift_up = accept;
               count_in     = count_ff + CNT_W'(1);
            end
         end
         MODE_REMOVE: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else begin
               cmd.shift_down = accept;
               count_in       = count_ff - CNT_W'(1);
            end
         end
         MODE_READ: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else begin
               rsp_read_byte_in = read_or;
            end
         end
         MODE_WRITE: begin
            if (pos_ext >= cnt_ext) begin
               rsp_status_in = ST_RANGE;
            end else begin
               cmd.load = accept;
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [BYTE_W-1:0] left_data;
      logic [BYTE_W-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = cell_data[g];
      end else begin : g_mid_left
         assign left_data = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_data = cell_data[g];
      end else begin : g_mid_right
         assign right_data = cell_data[g+1];
      end
      ibl_cell #(
         .INDEX (g),
         .CMP_W (CMP_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g]),
         .read_data  (cell_read[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // result payload, taken with each transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_byte_ff <= rsp_read_byte_in;
         rsp_count_ff     <= POS_W'(count_in);
         rsp_empty_ff     <= (count_in == '0);
         rsp_status_ff    <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_byte = rsp_read_byte_ff;
   assign rsp_count     = rsp_count_ff;
   assign rsp_empty_res = rsp_empty_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

/* bench/tb_indexed_byte_list.sv */
// tb_indexed_byte_list: self-checking bench for the indexed byte list, with a directed
// and a random request stream, a clocked driver and monitor, and an in-bench list predictor
// depends on ibl_pkg and indexed_byte_list from rtl
module tb_indexed_byte_list;
   timeunit 1ns;
   timeprecision 1ps;
   import ibl_pkg::*;

   localparam int CAPACITY = 16;
   localparam int RANDOM_ITEMS = 1920;
   localparam logic [MODE_W-1:0] MODE_UNUSED_5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_UNUSED_6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_UNUSED_7 = 3'd7;

   typedef struct {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  position;
      logic [BYTE_W-1:0] value;
   } list_req_type;

   typedef struct {
      logic [BYTE_W-1:0] read_byte;
      logic [POS_W-1:0]  count;
      logic              empty_res;
      logic [STAT_W-1:0] status;
   } list_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_W-1:0]  req_mode = '0;
   logic [POS_W-1:0]   req_position = '0;
   logic [BYTE_W-1:0]  req_value = '0;
   logic               rsp_valid;
   logic [BYTE_W-1:0]  rsp_read_byte;
   logic [POS_W-1:0]   rsp_count;
   logic               rsp_empty_res;
   logic [STAT_W-1:0]  rsp_status;

   list_req_type    request_queue[$];
   list_answer_type predicted_answers[$];
   list_req_type    in_flight;
   logic [BYTE_W-1:0] list_bytes[CAPACITY];
   int  list_len = 0;
   int  plan_len = 0;
   int  gap_left = 0;
   int  calm_left = 0;
   int  accepted_count = 0;
   int  total_items = 0;
   int  error_count = 0;

   indexed_byte_list #(.CAPACITY(CAPACITY)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_position(req_position), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_read_byte(rsp_read_byte), .rsp_count(rsp_count),
      .rsp_empty_res(rsp_empty_res), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic list_answer_type apply_list_request(list_req_type r);
      list_answer_type a;
      int i;
      a.read_byte = '0;
      a.status = ST_DONE;
      case (r.mode)
         MODE_INSERT: begin
            if (r.position > list_len) begin
               a.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               a.status = ST_FULL;
            end else begin
               for (i = list_len; i > r.position; i--) list_bytes[i] = list_bytes[i-1];
               list_bytes[r.position] = r.value;
               list_len++;
            end
         end
         MODE_REMOVE: begin
            if (r.position >= list_len) begin
               a.status = ST_RANGE;
            end else begin
               for (i = r.position; i + 1 < list_len; i++) list_bytes[i] = list_bytes[i+1];
               list_len--;
            end
         end
         MODE_READ: begin
            if (r.position >= list_len) a.status = ST_RANGE;
            else a.read_byte = list_bytes[r.position];
         end
         MODE_WRITE: begin
            if (r.position >= list_len) a.status = ST_RANGE;
            else list_bytes[r.position] = r.value;
         end
         MODE_CLEAR: begin
            list_len = 0;
         end
         default: begin
         end
      endcase
      a.count = list_len[POS_W-1:0];
      a.empty_res = (list_len == 0);
      return a;
   endfunction

   // rough length estimate used only to steer positions into range
   task automatic queue_request(logic [MODE_W-1:0] m, logic [POS_W-1:0] p, logic [BYTE_W-1:0] v);
      list_req_type r;
      r.mode = m;
      r.position = p;
      r.value = v;
      request_queue.push_back(r);
      if (m == MODE_INSERT && p <= plan_len && plan_len < CAPACITY) plan_len++;
      else if (m == MODE_REMOVE && p < plan_len) plan_len--;
      else if (m == MODE_CLEAR) plan_len = 0;
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      list_req_type nxt;
      int r;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predicted_answers.push_back(apply_list_request(in_flight));
            accepted_count++;
         end
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (request_queue.size() > 0) begin
               nxt = request_queue.pop_front();
               in_flight = nxt;
               start <= 1'b1;
               req_mode <= nxt.mode;
               req_position <= nxt.position;
               req_value <= nxt.value;
               if (calm_left > 0) begin
                  calm_left--;
                  gap_left = 0;
               end else begin
                  r = $urandom_range(99);
                  if (r < 2) calm_left = $urandom_range(30, 80);
                  if (r < 55) gap_left = 0;
                  else if (r < 90) gap_left = $urandom_range(1, 3);
                  else if (r < 97) gap_left = $urandom_range(4, 10);
                  else gap_left = $urandom_range(20, 60);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      list_answer_type want;
      if (!reset && rsp_valid) begin
         if (predicted_answers.size() == 0) begin
            $display("%0t unexpected transfer: expected none actual byte %0d count %0d",
                     $time, rsp_read_byte, rsp_count);
            error_count++;
         end else begin
            want = predicted_answers.pop_front();
            check_field("read_byte", want.read_byte, rsp_read_byte);
            check_field("count", want.count, rsp_count);
            check_field("empty_res", want.empty_res, rsp_empty_res);
            check_field("status", want.status, rsp_status);
         end
      end
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int n;
      int r;
      int fill_phase;
      int phase_left;
      logic [MODE_W-1:0] m;
      logic [POS_W-1:0] p;

      // empty list and unused modes
      queue_request(MODE_REMOVE, 5'd0, 8'd0);
      queue_request(MODE_READ, 5'd0, 8'd0);
      queue_request(MODE_WRITE, 5'd0, 8'hA5);
      queue_request(MODE_INSERT, 5'd1, 8'h11);
      queue_request(MODE_UNUSED_5, 5'd31, 8'hFF);
      queue_request(MODE_UNUSED_6, 5'd0, 8'h00);
      queue_request(MODE_UNUSED_7, 5'd16, 8'h5A);
      // fill to capacity: front, back and middle, then full, range, write, read, remove and clear cases
      queue_request(MODE_INSERT, 5'd0, 8'hFF);
      queue_request(MODE_INSERT, 5'd1, 8'h00);
      queue_request(MODE_INSERT, 5'd0, 8'h01);
      for (n = 3; n < CAPACITY; n++)
         queue_request(MODE_INSERT, POS_W'((n * 7) % (n + 1)), BYTE_W'($urandom_range(255)));
      queue_request(MODE_INSERT, 5'd16, 8'h55);
      queue_request(MODE_INSERT, 5'd17, 8'h66);
      queue_request(MODE_INSERT, 5'd0, 8'h77);
      queue_request(MODE_WRITE, 5'd15, 8'hFF);
      queue_request(MODE_READ, 5'd15, 8'd0);
      queue_request(MODE_READ, 5'd16, 8'd0);
      queue_request(MODE_REMOVE, 5'd15, 8'd0);
      queue_request(MODE_REMOVE, 5'd0, 8'd0);
      queue_request(MODE_REMOVE, 5'd31, 8'd0);
      queue_request(MODE_CLEAR, 5'd0, 8'd0);
      queue_request(MODE_READ, 5'd0, 8'd0);

      fill_phase = 1;
      phase_left = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            fill_phase = !fill_phase;
            phase_left = $urandom_range(40, 150);
         end
         phase_left--;
         r = $urandom_range(99);
         if (r < (fill_phase ? 45 : 15)) m = MODE_INSERT;
         else if (r < 60) m = MODE_REMOVE;
         else if (r < 80) m = MODE_READ;
         else if (r < 95) m = MODE_WRITE;
         else if (r < 97) m = MODE_CLEAR;
         else m = MODE_W'($urandom_range(5, 7));
         if ($urandom_range(99) < 15) p = POS_W'($urandom_range(31));
         else if (m == MODE_INSERT) p = POS_W'($urandom_range(plan_len));
         else if (plan_len > 0) p = POS_W'($urandom_range(plan_len - 1));
         else p = '0;
         queue_request(m, p, BYTE_W'($urandom_range(255)));
      end
      total_items = request_queue.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_items) @(negedge clock);
      while (predicted_answers.size() > 0) @(negedge clock);
      repeat (5) @(negedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
